[sv/campose_pkg.sv]
// campose_pkg: widths, payload types, command codes and constants of the camera pose core.
// Depends on nothing; used by the channel interfaces and camera_pose_update_core.
package campose_pkg;

  localparam int VEC_W    = 16;
  localparam int VEC_FRAC = 14;
  localparam int POS_W    = 32;
  localparam int AMT_W    = 32;
  localparam int ANG_W    = 34;

  typedef logic signed [VEC_W-1:0] vcomp_t;
  typedef vcomp_t [2:0]            vec3_t;
  typedef logic signed [POS_W-1:0] pcomp_t;
  typedef pcomp_t [2:0]            pos3_t;
  typedef logic signed [AMT_W-1:0] amt_t;
  typedef logic [2:0]              req_t;
  typedef logic [3:0]              wall_t;
  typedef logic [1:0]              vsel_t;

  localparam req_t REQ_YAW    = 3'd0;
  localparam req_t REQ_PITCH  = 3'd1;
  localparam req_t REQ_ROLL   = 3'd2;
  localparam req_t REQ_WALK   = 3'd3;
  localparam req_t REQ_STRAFE = 3'd4;
  localparam req_t REQ_FLY    = 3'd5;
  localparam req_t REQ_RESET  = 3'd6;

  localparam vsel_t V_ALONG = 2'd0;
  localparam vsel_t V_UP    = 2'd1;
  localparam vsel_t V_FWD   = 2'd2;

  localparam vcomp_t VEC_ONE  = vcomp_t'(1 << VEC_FRAC);
  localparam vcomp_t VEC_MONE = vcomp_t'(-(1 << VEC_FRAC));
  localparam vcomp_t VEC_ZERO = vcomp_t'(0);
  localparam vec3_t  ALONG_INIT = {VEC_ZERO, VEC_ZERO, VEC_ONE};
  localparam vec3_t  UP_INIT    = {VEC_ZERO, VEC_ONE, VEC_ZERO};
  localparam vec3_t  FWD_INIT   = {VEC_MONE, VEC_ZERO, VEC_ZERO};

  // angles in Q18.16 degrees
  localparam logic signed [ANG_W-1:0] DEG_90      = 34'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_180     = 34'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_360     = 34'sd23592960;
  localparam logic signed [ANG_W-1:0] ANG_BIAS    = 34'sd2170552320;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [39:0] POS_MAX40 = 40'sd2147483647;
  localparam logic signed [39:0] POS_MIN40 = -40'sd2147483648;

  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [3:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      4'd0:  v = 34'sd2949120;
      4'd1:  v = 34'sd1740967;
      4'd2:  v = 34'sd919879;
      4'd3:  v = 34'sd466945;
      4'd4:  v = 34'sd234379;
      4'd5:  v = 34'sd117305;
      4'd6:  v = 34'sd58665;
      4'd7:  v = 34'sd29335;
      4'd8:  v = 34'sd14668;
      4'd9:  v = 34'sd7334;
      4'd10: v = 34'sd3667;
      4'd11: v = 34'sd1833;
      4'd12: v = 34'sd917;
      4'd13: v = 34'sd458;
      4'd14: v = 34'sd229;
      default: v = 34'sd115;
    endcase
    return v;
  endfunction

endpackage

[sv/campose_if.sv]
// campose_cmd_if and campose_view_if: valid/ready channels of the camera pose core.
// Depends on campose_pkg for payload types.
interface campose_cmd_if import campose_pkg::*; ();
  logic  valid;
  logic  ready;
  req_t  req_type;
  amt_t  amount;
  wall_t wall_flags;
  modport source (output valid, req_type, amount, wall_flags, input ready);
  modport sink   (input valid, req_type, amount, wall_flags, output ready);
endinterface

interface campose_view_if import campose_pkg::*; ();
  logic   valid;
  logic   ready;
  vcomp_t right_x, right_y, right_z;
  vcomp_t up_x, up_y, up_z;
  vcomp_t back_x, back_y, back_z;
  pcomp_t trans_x, trans_y, trans_z;
  modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  back_x, back_y, back_z, trans_x, trans_y, trans_z, input ready);
  modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  back_x, back_y, back_z, trans_x, trans_y, trans_z, output ready);
endinterface

[sv/camera_pose_update_core.sv]
// camera_pose_update_core: camera pose keeper with one shared multiplier under a sequencer.
// Depends on campose_pkg and the channel interfaces in campose_if.sv.
//
// Usage:
//   in_cmd carries one command per transaction (yaw, pitch, roll, walk, strafe, fly,
//   reset pose). out_view carries the view matrix terms after each command that updates
//   the view. cfg_wr_en/cfg_wr_data write camera_mode (0 land, 1 air); the user writes it
//   only while idle, the block itself does not enforce this. in_cmd.ready is high only
//   while the sequencer is idle; one command is worked at a time.
//   A rotation runs 8 angle reduction steps, 16 CORDIC steps,
//   two normalizations (shift steps, three squares, 32 square root steps and three
//   16-step restoring divisions each), one vector product and three dot products, all
//   sharing one 34x32 multiplier and one add/compare path.
//   The result sits in an output register until taken; a new command is accepted while
//   it waits, and a finished command holds in its last step while the register is full.
//   Reset: camera_mode returns to air, pose returns to origin facing -z, no result pending.
module camera_pose_update_core import campose_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  campose_cmd_if.sink          in_cmd,
  campose_view_if.source       out_view
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED   = 5'd1;
  localparam logic [4:0] S_FOLD  = 5'd2;
  localparam logic [4:0] S_CORD  = 5'd3;
  localparam logic [4:0] S_SC    = 5'd4;
  localparam logic [4:0] S_TURN  = 5'd5;
  localparam logic [4:0] S_NMAX  = 5'd6;
  localparam logic [4:0] S_NSHF  = 5'd7;
  localparam logic [4:0] S_NSQ   = 5'd8;
  localparam logic [4:0] S_NSQRT = 5'd9;
  localparam logic [4:0] S_NDIV  = 5'd10;
  localparam logic [4:0] S_NWB   = 5'd11;
  localparam logic [4:0] S_XLD   = 5'd12;
  localparam logic [4:0] S_CROSS = 5'd13;
  localparam logic [4:0] S_MOVE  = 5'd14;
  localparam logic [4:0] S_DLD   = 5'd15;
  localparam logic [4:0] S_DMUL  = 5'd16;
  localparam logic [4:0] S_DFIN  = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  typedef logic signed [47:0] nwide_t;

  // ---------------------------------------------------------------- helpers
  function automatic vec3_t vec_of(input vsel_t sel, input vec3_t a, input vec3_t u,
                                   input vec3_t f);
    vec3_t v;
    case (sel)
      V_ALONG: v = a;
      V_UP:    v = u;
      default: v = f;
    endcase
    return v;
  endfunction

  function automatic vsel_t turn_tgt(input req_t c);
    vsel_t v;
    case (c)
      REQ_YAW:   v = V_ALONG;
      REQ_PITCH: v = V_FWD;
      default:   v = V_UP;
    endcase
    return v;
  endfunction

  function automatic vsel_t turn_oth(input req_t c);
    vsel_t v;
    case (c)
      REQ_YAW:   v = V_FWD;
      REQ_PITCH: v = V_UP;
      default:   v = V_ALONG;
    endcase
    return v;
  endfunction

  function automatic vsel_t x_a(input req_t c);
    vsel_t v;
    case (c)
      REQ_YAW: v = V_ALONG;
      default: v = V_FWD;
    endcase
    return v;
  endfunction

  function automatic vsel_t x_b(input req_t c);
    vsel_t v;
    case (c)
      REQ_PITCH: v = V_ALONG;
      default:   v = V_UP;
    endcase
    return v;
  endfunction

  function automatic vsel_t x_dst(input req_t c);
    vsel_t v;
    case (c)
      REQ_YAW:   v = V_FWD;
      REQ_PITCH: v = V_UP;
      default:   v = V_ALONG;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] nx1(input logic [1:0] j);
    logic [1:0] v;
    case (j)
      2'd0:    v = 2'd1;
      2'd1:    v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] nx2(input logic [1:0] j);
    logic [1:0] v;
    case (j)
      2'd0:    v = 2'd2;
      2'd1:    v = 2'd0;
      default: v = 2'd1;
    endcase
    return v;
  endfunction

  function automatic pcomp_t sat_pos(input logic signed [39:0] v);
    pcomp_t r;
    if (v > POS_MAX40) r = POS_MAX40[POS_W-1:0];
    else if (v < POS_MIN40) r = POS_MIN40[POS_W-1:0];
    else r = v[POS_W-1:0];
    return r;
  endfunction

  function automatic vcomp_t sat_vec(input logic signed [VEC_W:0] v);
    vcomp_t r;
    if (v > 17'sd32767) r = 16'sh7fff;
    else if (v < -17'sd32768) r = 16'sh8000;
    else r = v[VEC_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- state
  logic [4:0]              state_r;
  logic [1:0]              ph_r;
  logic [4:0]              k_r;
  logic [1:0]              j_r;
  logic                    stage_r;
  logic                    mode_r;
  req_t                    cmd_r;
  amt_t                    amt_r;
  wall_t                   wall_r;
  logic signed [ANG_W-1:0] ang_r, cx_r, cy_r;
  logic                    neg_r;
  vec3_t                   along_r, up_r, fwd_r, ta_r, tb_r, nres_r;
  pos3_t                   pos_r, trans_r;
  nwide_t                  t_r [3];
  logic [47:0]             m_r;
  logic [63:0]             sq_r, sqn_r, sqres_r, sqbit_r;
  logic [46:0]             num_r, dv_r;
  logic [15:0]             q_r;
  logic signed [49:0]      acc_r;
  logic signed [65:0]      prod_r;
  logic                    out_valid_r;
  vec3_t                   o_right_r, o_up_r, o_back_r;
  pos3_t                   o_trans_r;

  // ---------------------------------------------------------------- datapath
  logic signed [ANG_W-1:0] mul_a;
  logic signed [31:0]      mul_b;
  logic signed [65:0]      mul_p;
  logic signed [ANG_W-1:0] ang_in, red_d, fold1, fold_r;
  logic                    fold_neg;
  logic [47:0]             nm_abs [3];
  logic [47:0]             nm_max;
  logic [63:0]             sq_trial;
  logic [47:0]             div_abs;
  logic [46:0]             div_num;
  logic                    div_ge;
  logic [15:0]             div_q;
  logic signed [VEC_W:0]   div_sq;
  logic signed [49:0]      cross_diff;
  logic signed [65:0]      mv_round;
  logic signed [39:0]      mv_step;
  logic                    mv_pos, mv_neg, mv_blk;
  logic signed [49:0]      dot_round;
  logic signed [39:0]      dot_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TURN: begin
        if (ph_r == 2'd0) begin
          mul_a = cx_r;
          mul_b = 32'(ta_r[j_r]);
        end else begin
          mul_a = cy_r;
          mul_b = 32'(tb_r[j_r]);
        end
      end
      S_CROSS: begin
        if (ph_r == 2'd0) begin
          mul_a = ANG_W'(ta_r[nx1(j_r)]);
          mul_b = 32'(tb_r[nx2(j_r)]);
        end else begin
          mul_a = ANG_W'(ta_r[nx2(j_r)]);
          mul_b = 32'(tb_r[nx1(j_r)]);
        end
      end
      S_NSQ: begin
        mul_a = ANG_W'($signed(t_r[j_r][31:0]));
        mul_b = $signed(t_r[j_r][31:0]);
      end
      S_DMUL: begin
        mul_a = ANG_W'(pos_r[k_r[1:0]]);
        mul_b = 32'(ta_r[k_r[1:0]]);
      end
      S_MOVE: begin
        mul_a = ANG_W'(amt_r);
        mul_b = 32'(ta_r[j_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // angle entry: pitch turns the other way in air mode; bias keeps the value positive
  assign ang_in = ((in_cmd.req_type == REQ_PITCH) && mode_r) ?
                  -ANG_W'(in_cmd.amount) : ANG_W'(in_cmd.amount);
  assign red_d  = DEG_360 <<< k_r[2:0];

  always_comb begin
    fold1    = (ang_r > DEG_180) ? ang_r - DEG_360 : ang_r;
    fold_neg = 1'b0;
    fold_r   = fold1;
    if (fold1 > DEG_90) begin
      fold_r   = fold1 - DEG_180;
      fold_neg = 1'b1;
    end else if (fold1 < -DEG_90) begin
      fold_r   = fold1 + DEG_180;
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm_abs[i] = t_r[i][47] ? 48'(-t_r[i]) : 48'(t_r[i]);
    end
    nm_max = nm_abs[0];
    if (nm_abs[1] > nm_max) nm_max = nm_abs[1];
    if (nm_abs[2] > nm_max) nm_max = nm_abs[2];
  end

  assign sq_trial = sqres_r + sqbit_r;

  assign div_abs = t_r[j_r][47] ? 48'(-t_r[j_r]) : 48'(t_r[j_r]);
  assign div_num = (47'(div_abs[31:0]) << VEC_FRAC) + 47'(sqres_r[31:1]);
  assign div_ge  = (num_r >= dv_r);
  assign div_q   = {q_r[14:0], div_ge};
  assign div_sq  = t_r[j_r][47] ? -(VEC_W+1)'(div_q) : (VEC_W+1)'(div_q);

  assign cross_diff = acc_r - 50'(prod_r >>> 1);

  assign mv_round = prod_r + 66'sd8192;
  assign mv_step  = 40'(mv_round >>> VEC_FRAC);
  assign mv_pos   = !prod_r[65] && (prod_r != '0);
  assign mv_neg   = prod_r[65];
  assign mv_blk   = (j_r == 2'd0) ? ((wall_r[0] && mv_pos) || (wall_r[1] && mv_neg)) :
                                    ((wall_r[2] && mv_pos) || (wall_r[3] && mv_neg));

  assign dot_round = acc_r + 50'sd8192;
  assign dot_d     = 40'(dot_round >>> VEC_FRAC);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      k_r         <= '0;
      j_r         <= '0;
      stage_r     <= 1'b0;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
      along_r     <= ALONG_INIT;
      up_r        <= UP_INIT;
      fwd_r       <= FWD_INIT;
      pos_r       <= '0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      // the emit step reloads the register itself
      if (out_valid_r && out_view.ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_cmd.valid) begin
            cmd_r   <= in_cmd.req_type;
            amt_r   <= in_cmd.amount;
            wall_r  <= in_cmd.wall_flags;
            ph_r    <= '0;
            j_r     <= '0;
            stage_r <= 1'b0;
            case (in_cmd.req_type)
              REQ_YAW, REQ_PITCH, REQ_ROLL: begin
                if ((in_cmd.req_type != REQ_ROLL) || mode_r) begin
                  ta_r    <= vec_of(turn_tgt(in_cmd.req_type), along_r, up_r, fwd_r);
                  tb_r    <= vec_of(turn_oth(in_cmd.req_type), along_r, up_r, fwd_r);
                  ang_r   <= ang_in + ANG_BIAS;
                  k_r     <= 5'd7;
                  state_r <= S_RED;
                end
              end
              REQ_WALK: begin
                ta_r    <= fwd_r;
                state_r <= S_MOVE;
              end
              REQ_STRAFE: begin
                ta_r    <= along_r;
                state_r <= S_MOVE;
              end
              REQ_FLY: begin
                if (mode_r) begin
                  ta_r    <= up_r;
                  state_r <= S_MOVE;
                end
              end
              REQ_RESET: begin
                along_r <= ALONG_INIT;
                up_r    <= UP_INIT;
                fwd_r   <= FWD_INIT;
                pos_r   <= '0;
                state_r <= S_DLD;
              end
              default: ;
            endcase
          end
        end

        // floored modulo 360 by restoring subtraction of 360 << k
        S_RED: begin
          if (ang_r >= red_d) ang_r <= ang_r - red_d;
          if (k_r == 5'd0) state_r <= S_FOLD;
          else k_r <= k_r - 5'd1;
        end

        S_FOLD: begin
          ang_r   <= fold_r;
          neg_r   <= fold_neg;
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          k_r     <= '0;
          state_r <= S_CORD;
        end

        S_CORD: begin
          if (!ang_r[ANG_W-1]) begin
            cx_r  <= cx_r - (cy_r >>> k_r[3:0]);
            cy_r  <= cy_r + (cx_r >>> k_r[3:0]);
            ang_r <= ang_r - atan_deg(k_r[3:0]);
          end else begin
            cx_r  <= cx_r + (cy_r >>> k_r[3:0]);
            cy_r  <= cy_r - (cx_r >>> k_r[3:0]);
            ang_r <= ang_r + atan_deg(k_r[3:0]);
          end
          if (k_r == 5'(CORDIC_STEPS - 1)) state_r <= S_SC;
          else k_r <= k_r + 5'd1;
        end

        S_SC: begin
          if (neg_r) begin
            cx_r <= -cx_r;
            cy_r <= -cy_r;
          end
          j_r     <= '0;
          ph_r    <= '0;
          state_r <= S_TURN;
        end

        S_TURN: begin
          case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: begin
              acc_r <= 50'(prod_r);
              ph_r  <= 2'd2;
            end
            default: begin
              t_r[j_r] <= 48'(acc_r + 50'(prod_r));
              ph_r     <= 2'd0;
              if (j_r == 2'd2) state_r <= S_NMAX;
              else j_r <= j_r + 2'd1;
            end
          endcase
        end

        S_CROSS: begin
          case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: begin
              acc_r <= 50'(prod_r >>> 1);
              ph_r  <= 2'd2;
            end
            default: begin
              t_r[j_r] <= (cmd_r != REQ_ROLL) ? 48'(-cross_diff) : 48'(cross_diff);
              ph_r     <= 2'd0;
              if (j_r == 2'd2) state_r <= S_NMAX;
              else j_r <= j_r + 2'd1;
            end
          endcase
        end

        S_NMAX: begin
          m_r     <= nm_max;
          sq_r    <= '0;
          state_r <= S_NSHF;
        end

        // shift all three until the largest magnitude fits 31 bits
        S_NSHF: begin
          if (|m_r[47:31]) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 3; i++) t_r[i] <= t_r[i] >>> 1;
          end else begin
            j_r     <= '0;
            ph_r    <= '0;
            state_r <= S_NSQ;
          end
        end

        S_NSQ: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            sq_r <= sq_r + 64'(prod_r);
            ph_r <= 2'd0;
            if (j_r == 2'd2) begin
              sqn_r   <= sq_r + 64'(prod_r);
              sqres_r <= '0;
              sqbit_r <= 64'd1 << 62;
              k_r     <= '0;
              state_r <= S_NSQRT;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end
        end

        S_NSQRT: begin
          if (sqn_r >= sq_trial) begin
            sqn_r   <= sqn_r - sq_trial;
            sqres_r <= (sqres_r >> 1) + sqbit_r;
          end else begin
            sqres_r <= sqres_r >> 1;
          end
          sqbit_r <= sqbit_r >> 2;
          if (k_r == 5'd31) begin
            j_r     <= '0;
            ph_r    <= '0;
            state_r <= S_NDIV;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end

        // rounded quotient, one bit per cycle
        S_NDIV: begin
          if (ph_r == 2'd0) begin
            num_r <= div_num;
            dv_r  <= 47'(sqres_r[31:0]) << 15;
            q_r   <= '0;
            k_r   <= 5'd15;
            ph_r  <= 2'd1;
          end else begin
            if (div_ge) num_r <= num_r - dv_r;
            q_r  <= div_q;
            dv_r <= dv_r >> 1;
            if (k_r == 5'd0) begin
              nres_r[j_r] <= (sqres_r[31:0] == '0) ? VEC_ZERO : sat_vec(div_sq);
              ph_r        <= 2'd0;
              if (j_r == 2'd2) state_r <= S_NWB;
              else j_r <= j_r + 2'd1;
            end else begin
              k_r <= k_r - 5'd1;
            end
          end
        end

        S_NWB: begin
          case (stage_r ? x_dst(cmd_r) : turn_tgt(cmd_r))
            V_ALONG: along_r <= nres_r;
            V_UP:    up_r    <= nres_r;
            default: fwd_r   <= nres_r;
          endcase
          j_r <= '0;
          if (!stage_r) begin
            stage_r <= 1'b1;
            state_r <= S_XLD;
          end else begin
            state_r <= S_DLD;
          end
        end

        S_XLD: begin
          ta_r    <= vec_of(x_a(cmd_r), along_r, up_r, fwd_r);
          tb_r    <= vec_of(x_b(cmd_r), along_r, up_r, fwd_r);
          j_r     <= '0;
          ph_r    <= '0;
          state_r <= S_CROSS;
        end

        S_MOVE: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            if (mode_r) begin
              pos_r[j_r] <= sat_pos(40'(pos_r[j_r]) + mv_step);
            end else if ((j_r != 2'd1) && !mv_blk) begin
              pos_r[j_r] <= sat_pos(40'(pos_r[j_r]) - mv_step);
            end
            ph_r <= 2'd0;
            if (j_r == 2'd2) begin
              j_r     <= '0;
              // land strafe moves silently
              state_r <= (!mode_r && (cmd_r == REQ_STRAFE)) ? S_IDLE : S_DLD;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end
        end

        S_DLD: begin
          ta_r    <= vec_of(vsel_t'(j_r), along_r, up_r, fwd_r);
          acc_r   <= '0;
          k_r     <= '0;
          ph_r    <= '0;
          state_r <= S_DMUL;
        end

        S_DMUL: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            acc_r <= acc_r + 50'(prod_r);
            ph_r  <= 2'd0;
            if (k_r == 5'd2) state_r <= S_DFIN;
            else k_r <= k_r + 5'd1;
          end
        end

        S_DFIN: begin
          trans_r[j_r] <= sat_pos((j_r == 2'd2) ? dot_d : -dot_d);
          if (j_r == 2'd2) begin
            state_r <= S_EMIT;
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_DLD;
          end
        end

        // hold until the output register is free
        S_EMIT: begin
          if (!out_valid_r || out_view.ready) begin
            o_right_r <= along_r;
            o_up_r    <= up_r;
            for (int i = 0; i < 3; i++) begin
              o_back_r[i] <= sat_vec(-(VEC_W+1)'(fwd_r[i]));
            end
            o_trans_r   <= trans_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- ports
  assign in_cmd.ready     = (state_r == S_IDLE);
  assign out_view.valid   = out_valid_r;
  assign out_view.right_x = o_right_r[0];
  assign out_view.right_y = o_right_r[1];
  assign out_view.right_z = o_right_r[2];
  assign out_view.up_x    = o_up_r[0];
  assign out_view.up_y    = o_up_r[1];
  assign out_view.up_z    = o_up_r[2];
  assign out_view.back_x  = o_back_r[0];
  assign out_view.back_y  = o_back_r[1];
  assign out_view.back_z  = o_back_r[2];
  assign out_view.trans_x = o_trans_r[0];
  assign out_view.trans_y = o_trans_r[1];
  assign out_view.trans_z = o_trans_r[2];

endmodule

[tb/campose_checker.sv]
// campose_checker: watches the command, view and mode ports of camera_pose_update_core,
// predicts every view transaction from its own copy of the pose and compares.
// Depends on campose_pkg and the channel interfaces in campose_if.sv.
module campose_checker import campose_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_wr_en,
  input  logic   cfg_wr_data,
  campose_cmd_if  cmd,
  campose_view_if view,
  output int     mismatches,
  output int     pending,
  output int     cmd_count,
  output int     view_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint trip_t [0:2];
  typedef logic [11:0][31:0] view_t;

  localparam longint ONE_Q = 64'sd1 << VEC_FRAC;
  localparam longint TURN_360 = 64'sd360 <<< 16;
  localparam longint TURN_180 = 64'sd180 <<< 16;
  localparam longint TURN_90  = 64'sd90 <<< 16;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint LIM31    = 64'sd1 << 31;

  string field_name [12] = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z",
                             "back_x", "back_y", "back_z", "trans_x", "trans_y", "trans_z"};

  trip_t  cam_pos, cam_along, cam_up, cam_fwd;
  logic   air_mode;
  view_t  expected_views [$];

  function automatic longint clamp(longint v, int w);
    longint mx;
    mx = (64'sd1 <<< (w - 1)) - 1;
    if (v > mx) return mx;
    if (v < -mx - 1) return -mx - 1;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic trip_t unit_of(trip_t v);
    trip_t r, o;
    longint unsigned m, a, s, len, q;
    int sh;
    m = 0;
    s = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (a > m) m = a;
    end
    while ((m >> sh) >= LIM31) sh++;
    for (int i = 0; i < 3; i++) begin
      r[i] = v[i] >>> sh;
      a = (r[i] < 0) ? -r[i] : r[i];
      s += a * a;
    end
    len = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        a = (r[i] < 0) ? -r[i] : r[i];
        q = ((a << VEC_FRAC) + len / 2) / len;
        o[i] = clamp((r[i] < 0) ? -longint'(q) : longint'(q), VEC_W);
      end
    end
    return o;
  endfunction

  function automatic trip_t cross_half(trip_t a, trip_t b);
    trip_t o;
    o[0] = ((a[1] * b[2]) >>> 1) - ((a[2] * b[1]) >>> 1);
    o[1] = ((a[2] * b[0]) >>> 1) - ((a[0] * b[2]) >>> 1);
    o[2] = ((a[0] * b[1]) >>> 1) - ((a[1] * b[0]) >>> 1);
    return o;
  endfunction

  function automatic trip_t negate(trip_t a);
    trip_t o;
    for (int i = 0; i < 3; i++) o[i] = -a[i];
    return o;
  endfunction

  // v*cos + w*sin of an angle in Q16.16 degrees, CORDIC in Q2.30, then normalized
  function automatic trip_t rotate_toward(trip_t v, trip_t w, longint angle);
    longint r, x, y, nx, c, s;
    logic   flip;
    trip_t  t;
    r = angle % TURN_360;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (r < 0) r += TURN_360;
    if (r > TURN_180) r -= TURN_360;
    if (r > TURN_90) begin
      r -= TURN_180;
      flip = 1'b1;
    end else if (r < -TURN_90) begin
      r += TURN_180;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= longint'(atan_deg(4'(i)));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += longint'(atan_deg(4'(i)));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    for (int i = 0; i < 3; i++) t[i] = v[i] * c + w[i] * s;
    return unit_of(t);
  endfunction

  function automatic longint step_len(longint comp, longint d);
    return (comp * d + (64'sd1 <<< (VEC_FRAC - 1))) >>> VEC_FRAC;
  endfunction

  function automatic longint pos_dot(trip_t v, trip_t p);
    longint hi, lo, ph;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 3; i++) begin
      ph = p[i] >>> 24;
      hi += v[i] * ph;
      lo += v[i] * (p[i] - ph * (64'sd1 <<< 24));
    end
    return hi * (64'sd1 <<< (24 - VEC_FRAC)) + ((lo + (64'sd1 <<< (VEC_FRAC - 1))) >>> VEC_FRAC);
  endfunction

  function automatic logic wall_hit(longint comp, longint d, logic plus_w, logic minus_w);
    logic same, opp;
    same = (comp > 0 && d > 0) || (comp < 0 && d < 0);
    opp  = (comp > 0 && d < 0) || (comp < 0 && d > 0);
    return (plus_w && same) || (minus_w && opp);
  endfunction

  task automatic home_pose();
    cam_pos   = '{0, 0, 0};
    cam_along = '{ONE_Q, 0, 0};
    cam_up    = '{0, ONE_Q, 0};
    cam_fwd   = '{0, 0, -ONE_Q};
  endtask

  task automatic drift(trip_t v, longint d, logic land, logic [3:0] walls);
    if (land) begin
      if (!wall_hit(v[0], d, walls[0], walls[1]))
        cam_pos[0] = clamp(cam_pos[0] - step_len(v[0], d), POS_W);
      if (!wall_hit(v[2], d, walls[2], walls[3]))
        cam_pos[2] = clamp(cam_pos[2] - step_len(v[2], d), POS_W);
    end else begin
      for (int i = 0; i < 3; i++) cam_pos[i] = clamp(cam_pos[i] + step_len(v[i], d), POS_W);
    end
  endtask

  function automatic view_t view_terms();
    view_t e;
    for (int i = 0; i < 3; i++) begin
      e[i]     = 32'(cam_along[i]);
      e[3 + i] = 32'(cam_up[i]);
      e[6 + i] = 32'(clamp(-cam_fwd[i], VEC_W));
    end
    e[9]  = 32'(clamp(-pos_dot(cam_along, cam_pos), POS_W));
    e[10] = 32'(clamp(-pos_dot(cam_up, cam_pos), POS_W));
    e[11] = 32'(clamp(pos_dot(cam_fwd, cam_pos), POS_W));
    return e;
  endfunction

  // apply one command to the pose; returns 1 when the view is answered
  task automatic advance_pose(req_t req, longint d, logic [3:0] walls, output logic answered);
    answered = 1'b1;
    case (req)
      REQ_YAW: begin
        cam_along = rotate_toward(cam_along, cam_fwd, d);
        cam_fwd   = unit_of(negate(cross_half(cam_along, cam_up)));
      end
      REQ_PITCH: begin
        cam_fwd = rotate_toward(cam_fwd, cam_up, air_mode ? -d : d);
        cam_up  = unit_of(negate(cross_half(cam_fwd, cam_along)));
      end
      REQ_ROLL: begin
        if (!air_mode) answered = 1'b0;
        else begin
          cam_up    = rotate_toward(cam_up, cam_along, d);
          cam_along = unit_of(cross_half(cam_fwd, cam_up));
        end
      end
      REQ_WALK:   drift(cam_fwd, d, !air_mode, walls);
      REQ_STRAFE: begin
        drift(cam_along, d, !air_mode, walls);
        if (!air_mode) answered = 1'b0;
      end
      REQ_FLY: begin
        if (!air_mode) answered = 1'b0;
        else drift(cam_up, d, 1'b0, walls);
      end
      REQ_RESET: home_pose();
      default: answered = 1'b0;
    endcase
  endtask

  always @(posedge clk) begin
    logic  answered;
    view_t got, want;
    logic  bad;
    if (!rst_n) begin
      air_mode <= 1'b1;
      home_pose();
      expected_views.delete();
      mismatches <= 0;
      cmd_count  <= 0;
      view_count <= 0;
    end else begin
      if (cfg_wr_en) air_mode <= cfg_wr_data;
      if (cmd.valid && cmd.ready) begin
        cmd_count <= cmd_count + 1;
        advance_pose(cmd.req_type, longint'(cmd.amount), cmd.wall_flags, answered);
        if (answered) expected_views.push_back(view_terms());
      end
      if (view.valid && view.ready) begin
        view_count <= view_count + 1;
        got = {32'(view.trans_z), 32'(view.trans_y), 32'(view.trans_x),
               32'(view.back_z), 32'(view.back_y), 32'(view.back_x),
               32'(view.up_z), 32'(view.up_y), 32'(view.up_x),
               32'(view.right_z), 32'(view.right_y), 32'(view.right_x)};
        if (expected_views.size() == 0) begin
          if (mismatches < 10) $display("ERROR: view transaction with nothing expected");
          mismatches <= mismatches + 1;
        end else begin
          want = expected_views.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 12; i++) begin
            if (got[i] !== want[i]) begin
              if (mismatches < 10 && !bad)
                $display("ERROR: view %0d %s expected %0d got %0d", view_count,
                         field_name[i], $signed(want[i]), $signed(got[i]));
              bad = 1'b1;
            end
          end
          if (bad) mismatches <= mismatches + 1;
        end
      end
    end
  end

  assign pending = expected_views.size();

endmodule

[tb/tb_camera_pose_update_core.sv]
// tb_camera_pose_update_core: drives commands and mode writes into camera_pose_update_core
// with random gaps and stalls; campose_checker predicts and compares the view output.
// Depends on campose_pkg, campose_if.sv, the core and tb/campose_checker.sv.
module tb_camera_pose_update_core import campose_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic calm = 1'b0;
  int   mismatches, pending, cmd_count, view_count;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  int   mode_writes = 0;

  campose_cmd_if  cmd_if ();
  campose_view_if view_if ();

  camera_pose_update_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (cmd_if),
    .out_view    (view_if)
  );

  campose_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_if),
    .view        (view_if),
    .mismatches  (mismatches),
    .pending     (pending),
    .cmd_count   (cmd_count),
    .view_count  (view_count)
  );

  always #5 clk = ~clk;

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.req_type = REQ_YAW;
    cmd_if.amount = '0;
    cmd_if.wall_flags = '0;
    view_if.ready = 1'b0;
  end

  // receiver: after each view transaction hold ready low for a random stretch
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      view_if.ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) view_if.ready <= 1'b1;
    end else if (view_if.valid && view_if.ready) begin
      stall = calm ? 0 : $urandom_range(0, 18);
      hold_left <= stall;
      if (stall > 0) view_if.ready <= 1'b0;
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (view_if.valid && view_if.ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_cmd(req_t req, amt_t amt, wall_t walls);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.req_type <= req;
    cmd_if.amount <= amt;
    cmd_if.wall_flags <= walls;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // drain, let a silent command finish, then write the mode
  task automatic set_mode(logic m);
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_writes++;
  endtask

  function automatic amt_t degrees(int d);
    return amt_t'(d) <<< 16;
  endfunction

  task automatic random_cmd();
    int   pick;
    req_t req;
    amt_t amt;
    pick = $urandom_range(0, 99);
    if (pick < 18)      req = REQ_YAW;
    else if (pick < 33) req = REQ_PITCH;
    else if (pick < 45) req = REQ_ROLL;
    else if (pick < 67) req = REQ_WALK;
    else if (pick < 82) req = REQ_STRAFE;
    else if (pick < 93) req = REQ_FLY;
    else if (pick < 97) req = REQ_RESET;
    else                req = req_t'(7);
    case ($urandom_range(0, 9))
      0, 1:    amt = amt_t'($urandom);
      2:       amt = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3, 4, 5: amt = degrees($urandom_range(0, 720) - 360) + amt_t'($urandom_range(0, 65535));
      default: amt = amt_t'($urandom_range(0, 2 * 65536 * 60)) - amt_t'(65536 * 60);
    endcase
    send_cmd(req, amt, wall_t'($urandom_range(0, 15)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: air mode after reset
    calm = 1'b1;
    send_cmd(REQ_YAW, degrees(90), 4'h0);
    send_cmd(REQ_PITCH, degrees(-45), 4'h0);
    send_cmd(REQ_ROLL, degrees(30), 4'h0);
    send_cmd(REQ_YAW, degrees(180), 4'h0);
    send_cmd(REQ_YAW, degrees(-180), 4'h0);
    send_cmd(REQ_PITCH, 32'sh7fffffff, 4'h0);
    send_cmd(REQ_ROLL, 32'sh80000000, 4'h0);
    send_cmd(REQ_YAW, '0, 4'h0);
    send_cmd(REQ_WALK, 32'sh7fffffff, 4'h0);
    send_cmd(REQ_WALK, 32'sh7fffffff, 4'h0);
    send_cmd(REQ_STRAFE, 32'sh80000000, 4'hf);
    send_cmd(REQ_FLY, 32'sh80000000, 4'h0);
    send_cmd(REQ_FLY, 32'sh80000000, 4'h0);
    send_cmd(REQ_RESET, '0, 4'h0);
    send_cmd(req_t'(7), 32'sh12345678, 4'h5);

    // directed: land mode, walls and refused commands
    set_mode(1'b0);
    send_cmd(REQ_YAW, degrees(30), 4'h0);
    send_cmd(REQ_PITCH, degrees(20), 4'h0);
    send_cmd(REQ_WALK, degrees(10), 4'h1);
    send_cmd(REQ_WALK, degrees(-10), 4'h2);
    send_cmd(REQ_WALK, degrees(10), 4'h4);
    send_cmd(REQ_WALK, degrees(-10), 4'h8);
    send_cmd(REQ_STRAFE, degrees(5), 4'h0);
    send_cmd(REQ_ROLL, degrees(45), 4'h0);
    send_cmd(REQ_FLY, degrees(5), 4'h0);
    send_cmd(REQ_WALK, 32'sh80000000, 4'h0);

    // random phases alternating the mode
    calm = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph[0]);
      calm = (ph == 3);
      for (int n = 0; n < 100; n++) random_cmd();
    end
    calm = 1'b0;

    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d commands over %0d mode writes, checked %0d view results",
             cmd_count, mode_writes, view_count);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, views still expected: %0d", mismatches, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
